FILE: hw/rtl/cmop_pkg.sv
// ----------------------------------------------------------------------------
// cmop_pkg: shared definitions for the cursor mask / outline / premultiply block
// Pixel constants, register indexes, queue sizing and the types that pass
// between the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package cmop_pkg;

	// image geometry limits
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 9;

	// pixel words
	localparam int          PIX_W      = 32;
	localparam logic [31:0] PIX_BLACK  = 32'hFF00_0000;
	localparam logic [31:0] PIX_WHITE  = 32'hFFFF_FFFF;
	localparam logic [31:0] PIX_CLEAR  = 32'h0000_0000;
	localparam logic [31:0] MASK_WHITE = 32'h00FF_FFFF;

	// item kinds
	localparam logic CMD_PIXEL = 1'b0;

	// configuration port
	localparam int              CFG_IDX_W         = 3;
	localparam int              CFG_DATA_W        = 9;
	localparam logic [2:0]      REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0]      REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0]      REG_COMBINE_MASK  = 3'd2;
	localparam logic [2:0]      REG_OUTLINE       = 3'd3;
	localparam logic [2:0]      REG_PREMULTIPLY   = 3'd4;
	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 9'd32;
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 9'd32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = QPTR_W + 1;

	// settings seen by the front
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             combine;
		logic             outline;
	} cmop_cfg_t;

	// one queued result
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} cmop_item_t;

	// clamp a geometry register to 1..lim
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cmop_front.sv
// ----------------------------------------------------------------------------
// cmop_front: accept, combine, classify and outline
// Combines each pixel with its mask, keeps the two-row line store, tracks
// column and row, and finishes the outline of the delayed center pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cmop_front import cmop_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmop_cfg_t         cfg,
	input  wire logic              restart,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_cmd,
	input  wire logic [PIX_W-1:0]  in_color,
	input  wire logic [PIX_W-1:0]  in_mask,
	input  wire logic [QLVL_W-1:0] q_level,
	output logic                   push,
	output cmop_item_t             push_item
);

	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [COL_W-1:0] col_nx;
	logic             accept;
	logic             is_pix;
	logic             pix_take;
	logic             flush_take;
	logic             produce;
	logic             last_col;
	logic [PIX_W-1:0] pix_v;

	// line store: one bank per row parity
	logic [PIX_W-1:0] row_bank0 [MAX_WIDTH];
	logic [PIX_W-1:0] row_bank1 [MAX_WIDTH];
	logic [PIX_W-1:0] b0_a_s1, b0_b_s1, b1_a_s1, b1_b_s1;

	// stage 1 control
	logic             valid_s1;
	logic             par_s1;
	logic             has_up_s1, has_down_s1, has_left_s1, has_right_s1;
	logic [PIX_W-1:0] down_s1;
	logic             last_s1;
	logic [PIX_W-1:0] left_q;

	logic [PIX_W-1:0] up_w, center_w, right_w;
	logic             hit;
	logic [QLVL_W:0]  fill;

	// hold off while queue plus the beat in stage 1 could overflow
	assign fill     = {1'b0, q_level} + (QLVL_W+1)'(valid_s1);
	assign in_ready = fill < (QLVL_W+1)'(QUEUE_DEPTH);
	assign accept   = in_valid & in_ready;

	// classify the beat
	assign is_pix     = (in_cmd == CMD_PIXEL);
	assign pix_take   = is_pix && (row_q < cfg.height);
	assign flush_take = !is_pix && (row_q >= cfg.height);
	assign produce    = (pix_take && (row_q != '0)) || flush_take;
	assign last_col   = ({1'b0, col_q} + DIM_W'(1)) == cfg.width;
	assign col_nx     = col_q + COL_W'(1);

	// mask combination
	always_comb begin
		pix_v = in_color;
		if (cfg.combine) begin
			if (in_mask == MASK_WHITE) begin
				pix_v = (in_color != '0) ? PIX_BLACK : PIX_CLEAR;
			end else begin
				pix_v = in_color ^ PIX_BLACK;
			end
		end
	end

	// advance column and row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pix_take) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_nx;
				end
			end else if (flush_take) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_nx;
				end
			end
		end
	end

	// bank 0: read column and column+1, write the current row
	always_ff @(posedge clk) begin
		b0_a_s1 <= row_bank0[col_q];
		b0_b_s1 <= row_bank0[col_nx];
		if (accept && pix_take && !row_q[0]) begin
			row_bank0[col_q] <= pix_v;
		end
	end

	// bank 1: same ports for odd rows
	always_ff @(posedge clk) begin
		b1_a_s1 <= row_bank1[col_q];
		b1_b_s1 <= row_bank1[col_nx];
		if (accept && pix_take && row_q[0]) begin
			row_bank1[col_q] <= pix_v;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && produce && !restart;
		end
	end

	// stage 1 neighbor flags and down pixel
	always_ff @(posedge clk) begin
		par_s1       <= row_q[0];
		has_up_s1    <= row_q >= DIM_W'(2);
		has_down_s1  <= is_pix;
		has_left_s1  <= col_q != '0;
		has_right_s1 <= !last_col;
		down_s1      <= pix_v;
		last_s1      <= flush_take && last_col;
	end

	// pick up, center and right by row parity
	always_comb begin
		up_w     = par_s1 ? b1_a_s1 : b0_a_s1;
		center_w = par_s1 ? b0_a_s1 : b1_a_s1;
		right_w  = par_s1 ? b0_b_s1 : b1_b_s1;
	end

	// keep the last center as the next left neighbor
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_q <= center_w;
		end
	end

	// outline a clear pixel that touches black, when outline is enabled
	always_comb begin
		hit = (has_up_s1 && (up_w == PIX_BLACK))
			|| (has_down_s1 && (down_s1 == PIX_BLACK))
			|| (has_left_s1 && (left_q == PIX_BLACK))
			|| (has_right_s1 && (right_w == PIX_BLACK));
		push_item.pixel = center_w;
		if (cfg.outline && (center_w == PIX_CLEAR) && hit) begin
			push_item.pixel = PIX_WHITE;
		end
		push_item.last = last_s1;
	end

	assign push = valid_s1;

endmodule

`default_nettype wire

FILE: hw/rtl/cmop_queue.sv
// ----------------------------------------------------------------------------
// cmop_queue: short result queue
// Decouples the front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cmop_queue import cmop_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cmop_item_t        push_item,
	input  wire logic              pop,
	output logic                   not_empty,
	output cmop_item_t             head,
	output logic [QLVL_W-1:0]      level
);

	cmop_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QLVL_W-1:0] count_q;

	assign not_empty = count_q != '0;
	assign head      = slot_q[rptr_q];
	assign level     = count_q;

	// store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QLVL_W'(1);
				2'b01:   count_q <= count_q - QLVL_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cmop_back.sv
// ----------------------------------------------------------------------------
// cmop_back: premultiply and output register
// Pops the queue, scales blue, green and red by alpha/255 when premultiply
// is enabled and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cmop_back import cmop_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             premul_en,
	input  wire logic             q_valid,
	input  wire cmop_item_t       q_item,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [PIX_W-1:0]      out_pixel,
	output logic                  out_last
);

	logic             valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic             last_q;
	logic [PIX_W-1:0] scaled;
	logic [7:0]       alpha;
	logic [15:0]      prod [3];
	logic [16:0]      corr [3];

	// floor(c * a / 255) = (n + (n >> 8) + 1) >> 8 for n = c * a
	always_comb begin
		alpha = q_item.pixel[31:24];
		scaled = q_item.pixel;
		for (int i = 0; i < 3; i++) begin
			prod[i] = 16'(q_item.pixel[i*8 +: 8]) * 16'(alpha);
			corr[i] = 17'(prod[i]) + 17'(prod[i][15:8]) + 17'd1;
			if (premul_en) begin
				scaled[i*8 +: 8] = corr[i][15:8];
			end
		end
	end

	// take the head when the output register is free or being drained
	assign pop = q_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q <= scaled;
			last_q  <= q_item.last;
		end
	end

	assign out_valid = valid_q;
	assign out_pixel = pixel_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cursor_mask_outline_premultiply.sv
// ----------------------------------------------------------------------------
// cursor_mask_outline_premultiply: cursor pixel combiner with outline
// Turns AND-mask cursor pixels into RGBA, adds a white outline around black
// and premultiplies color by alpha, one row behind the input.
//
//   channel   dir  handshake                      contents
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser: cmd, tdata: color, mask
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: out_pixel, tlast: last
//   cfg       in   cfg_wr_en                      cfg_index, cfg_wdata
//
// One beat per clock in and out while m_axis is not stalled. On its way to
// m_axis a result passes the stage 1 registers, which take the line store
// read as its input beat is taken, then the queue and the output register.
// The four-entry queue sets how long the input keeps taking beats while the
// output is stalled. Reset clears counters and control, not the line store.
// A write to the width or height register restarts the image.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_mask_outline_premultiply import cmop_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [63:0]           s_axis_tdata,   // pixel_color, mask_word
	input  wire logic                  s_axis_tuser,   // cmd
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [31:0]                m_axis_tdata,   // out_pixel
	output logic                       m_axis_tlast,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic              combine_q;
	logic              outline_q;
	logic              premul_q;
	logic              restart;
	cmop_cfg_t         cfg;

	logic              push;
	cmop_item_t        push_item;
	logic              pop;
	logic              q_valid;
	cmop_item_t        q_head;
	logic [QLVL_W-1:0] q_level;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			combine_q      <= 1'b1;
			outline_q      <= 1'b0;
			premul_q       <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				REG_COMBINE_MASK: combine_q      <= cfg_wdata[0];
				REG_OUTLINE:      outline_q      <= cfg_wdata[0];
				REG_PREMULTIPLY:  premul_q       <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// restart the image on a geometry write
	assign restart = cfg_wr_en
		&& ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

	always_comb begin
		cfg.width   = clamp_dim(image_width_q, DIM_W'(MAX_WIDTH));
		cfg.height  = clamp_dim(image_height_q, DIM_W'(MAX_HEIGHT));
		cfg.combine = combine_q;
		cfg.outline = outline_q;
	end

	cmop_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.restart   (restart),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_color  (s_axis_tdata[31:0]),
		.in_mask   (s_axis_tdata[63:32]),
		.q_level   (q_level),
		.push      (push),
		.push_item (push_item)
	);

	cmop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head),
		.level     (q_level)
	);

	cmop_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.premul_en (premul_q),
		.q_valid   (q_valid),
		.q_item    (q_head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pixel (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire
